@@ hdl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit allocator
// Holds status codes, controller states and the controller/datapath structs.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam logic [31:0] PageMaskLow  = 32'h0000_0fff;
  localparam logic [31:0] PageMaskHigh = 32'hffff_f000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_LOST    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ASCAN,
    S_AWAIT,
    S_FSCAN,
    S_FWAIT,
    S_FDECIDE,
    S_SHIFT,
    S_SHWAIT,
    S_DONE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;        // latch the input word
    logic rd;          // read table at index or, while shifting, its neighbour
    logic idx_clr;     // index := 0
    logic idx_inc;     // index := index + 1
    logic idx_dec;     // index := index - 1
    logic rd_prev;     // read entry index-1 as well (free decision)
    logic a_hit;       // allocate hit at index: update
    logic a_fail;      // allocate miss
    logic f_decide;    // free decision step
    logic sh_step;     // shift step (copy one entry)
    logic sh_end;      // shift done: write final entry of an insert
    logic emit;        // load output register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_free;
    logic at_end;      // index == count
    logic fit;         // read length >= size
    logic gt;          // read start > addr
    logic zero_after;  // length after carve is zero
    logic need_shift;  // decision needs a shift pass
    logic shift_down;  // shift toward lower indexes (remove)
    logic shift_last;  // shift reached its end
  } sts_t;

endpackage

@@ hdl/ffa_if.sv @@
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if: valid/ready channels of the allocator
// Request and result channels with source and sink modports.
// ----------------------------------------------------------------------------
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        round_to_page;
  logic [31:0] region_addr;
  logic [31:0] region_size;
  modport source (output valid, mode, round_to_page, region_addr, region_size, input ready);
  modport sink   (input valid, mode, round_to_page, region_addr, region_size, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] granted_addr;
  logic [31:0] free_bytes;
  logic [8:0]  region_count;
  logic [8:0]  peak_regions;
  logic [31:0] lost_regions;
  logic [31:0] lost_bytes;
  modport source (output valid, status, granted_addr, free_bytes, region_count,
                  peak_regions, lost_regions, lost_bytes, input ready);
  modport sink   (input valid, status, granted_addr, free_bytes, region_count,
                  peak_regions, lost_regions, lost_bytes, output ready);
endinterface

@@ hdl/ffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffa_ctrl: request sequencer of the allocator
// Steps scan, decision and shift passes over the region table.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  input  ffa_pkg::sts_t   sts_i,
  output ffa_pkg::cmd_t   cmd_o
);

  ffa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ffa_pkg::S_FSCAN;
      end
      ffa_pkg::S_FSCAN: begin
        // dispatch on latched mode
        if (sts_i.is_free) begin
          state_d = sts_i.at_end ? ffa_pkg::S_FDECIDE : ffa_pkg::S_FWAIT;
        end else begin
          state_d = sts_i.at_end ? ffa_pkg::S_DONE : ffa_pkg::S_AWAIT;
        end
      end
      ffa_pkg::S_ASCAN: begin
        state_d = sts_i.at_end ? ffa_pkg::S_DONE : ffa_pkg::S_AWAIT;
      end
      ffa_pkg::S_AWAIT: begin
        if (sts_i.fit) begin
          state_d = sts_i.zero_after ? ffa_pkg::S_SHIFT : ffa_pkg::S_DONE;
        end else begin
          state_d = ffa_pkg::S_ASCAN;
        end
      end
      ffa_pkg::S_FWAIT: begin
        state_d = sts_i.gt ? ffa_pkg::S_FDECIDE : ffa_pkg::S_ASCAN;
        if (!sts_i.gt) state_d = ffa_pkg::S_FSCAN;
      end
      ffa_pkg::S_FDECIDE: begin
        state_d = sts_i.need_shift ? ffa_pkg::S_SHIFT : ffa_pkg::S_DONE;
      end
      ffa_pkg::S_SHIFT: begin
        state_d = sts_i.shift_last ? ffa_pkg::S_DONE : ffa_pkg::S_SHWAIT;
      end
      ffa_pkg::S_SHWAIT: state_d = ffa_pkg::S_SHIFT;
      ffa_pkg::S_DONE: begin
        if (out_free_i) state_d = ffa_pkg::S_IDLE;
      end
      default: state_d = ffa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ffa_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.take    = in_valid_i;
        cmd_o.idx_clr = in_valid_i;
      end
      ffa_pkg::S_FSCAN, ffa_pkg::S_ASCAN: begin
        cmd_o.rd = !sts_i.at_end;
        if (sts_i.at_end) begin
          if (sts_i.is_free) cmd_o.rd_prev = 1'b1;
          else cmd_o.a_fail = 1'b1;
        end
      end
      ffa_pkg::S_AWAIT: begin
        if (sts_i.fit) cmd_o.a_hit = 1'b1;
        else cmd_o.idx_inc = 1'b1;
      end
      ffa_pkg::S_FWAIT: begin
        if (sts_i.gt) cmd_o.rd_prev = 1'b1;
        else cmd_o.idx_inc = 1'b1;
      end
      ffa_pkg::S_FDECIDE: cmd_o.f_decide = 1'b1;
      ffa_pkg::S_SHIFT: begin
        if (sts_i.shift_last) cmd_o.sh_end = 1'b1;
        else cmd_o.rd = 1'b1;
      end
      ffa_pkg::S_SHWAIT: begin
        cmd_o.sh_step = 1'b1;
        if (sts_i.shift_down) cmd_o.idx_inc = 1'b1;
        else cmd_o.idx_dec = 1'b1;
      end
      ffa_pkg::S_DONE: cmd_o.emit = out_free_i;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hdl/ffa_dp.sv @@
// ----------------------------------------------------------------------------
// ffa_dp: region table and arithmetic of the allocator
// Holds the start/length memories, counters and the result register.
// ----------------------------------------------------------------------------
module ffa_dp #(
  parameter int unsigned TableEntries = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffa_pkg::cmd_t       cmd_i,
  output ffa_pkg::sts_t       sts_o,
  input  logic                mode_i,
  input  logic                round_i,
  input  logic [31:0]         addr_i,
  input  logic [31:0]         size_i,
  output logic [1:0]          status_o,
  output logic [31:0]         granted_o,
  output logic [31:0]         free_o,
  output logic [8:0]          count_o,
  output logic [8:0]          peak_o,
  output logic [31:0]         lost_n_o,
  output logic [31:0]         lost_b_o
);

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  logic [31:0] mem_start [TableEntries];
  logic [31:0] mem_len   [TableEntries];

  logic        mode_q;
  logic [31:0] addr_q, size_q;
  logic [CntW-1:0] idx_q, cnt_q, peak_q, sh_end_q;
  logic [31:0] rs_q, rl_q;       // read entry
  logic [31:0] ps_q, pl_q;       // held previous entry
  logic [31:0] ws_q, wl_q;       // final entry of a shift
  logic        sh_down_q;
  logic        rd_is_shift_q;
  logic [31:0] free_q, lost_n_q, lost_b_q;
  logic [1:0]  st_q;
  logic [31:0] gr_q;

  logic [31:0] size_r;
  assign size_r = round_i ? ((size_i + ffa_pkg::PageMaskLow) & ffa_pkg::PageMaskHigh)
                          : size_i;

  // free decision terms
  logic has_prev, has_next, m_prev, m_next;
  logic [31:0] end_a;
  assign end_a    = addr_q + size_q;
  assign has_prev = idx_q != '0;
  assign has_next = idx_q != cnt_q;
  assign m_prev   = has_prev && (ps_q + pl_q == addr_q);
  assign m_next   = has_next && (end_a == rs_q);

  logic [CntW-1:0] idx_m1;
  assign idx_m1 = idx_q - 1'b1;

  logic [IdxW-1:0] rd_addr;
  always_comb begin
    rd_addr = idx_q[IdxW-1:0];
    if (cmd_i.rd_prev) rd_addr = idx_m1[IdxW-1:0];
    if (cmd_i.rd && !sh_down_q && sts_o.shift_last == 1'b0 && cmd_i.sh_step == 1'b0 &&
        mode_q && idx_q != '0 && rd_is_shift_q) rd_addr = idx_m1[IdxW-1:0];
    if (cmd_i.rd && sh_down_q && rd_is_shift_q) rd_addr = idx_q[IdxW-1:0] + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rs_q <= mem_start[rd_addr];
      rl_q <= mem_len[rd_addr];
    end
    if (cmd_i.rd_prev) begin
      ps_q <= mem_start[rd_addr];
      pl_q <= mem_len[rd_addr];
      rs_q <= mem_start[idx_q[IdxW-1:0]];
    end
    if (cmd_i.a_hit) begin
      mem_start[idx_q[IdxW-1:0]] <= rs_q + size_q;
      mem_len[idx_q[IdxW-1:0]]   <= rl_q - size_q;
    end
    if (cmd_i.f_decide) begin
      if (m_prev) mem_len[idx_m1[IdxW-1:0]] <= m_next ? pl_q + size_q + rl_q : pl_q + size_q;
      else if (m_next) begin
        mem_start[idx_q[IdxW-1:0]] <= addr_q;
        mem_len[idx_q[IdxW-1:0]]   <= rl_q + size_q;
      end
    end
    if (cmd_i.sh_step) begin
      if (sh_down_q) begin
        mem_start[idx_q[IdxW-1:0]] <= rs_q;
        mem_len[idx_q[IdxW-1:0]]   <= rl_q;
      end else begin
        mem_start[idx_q[IdxW-1:0]] <= rs_q;
        mem_len[idx_q[IdxW-1:0]]   <= rl_q;
      end
    end
    if (cmd_i.sh_end && !sh_down_q) begin
      mem_start[idx_q[IdxW-1:0]] <= ws_q;
      mem_len[idx_q[IdxW-1:0]]   <= wl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= mode_i;
      addr_q <= addr_i;
      size_q <= size_r;
    end
    if (cmd_i.a_hit) gr_q <= rs_q;
    if (cmd_i.take) gr_q <= '0;
    if (cmd_i.f_decide) begin
      ws_q <= addr_q;
      wl_q <= size_q;
    end
  end

  // Index, shift bookkeeping and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      cnt_q         <= '0;
      peak_q        <= '0;
      sh_end_q      <= '0;
      sh_down_q     <= 1'b0;
      rd_is_shift_q <= 1'b0;
      free_q        <= '0;
      lost_n_q      <= '0;
      lost_b_q      <= '0;
      st_q          <= ffa_pkg::ST_OK;
    end else begin
      if (cmd_i.idx_clr) idx_q <= '0;
      if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
      if (cmd_i.idx_dec) idx_q <= idx_m1;
      if (cmd_i.take) begin
        st_q          <= ffa_pkg::ST_OK;
        rd_is_shift_q <= 1'b0;
      end
      if (cmd_i.a_fail) st_q <= ffa_pkg::ST_NO_FIT;
      if (cmd_i.a_hit) begin
        free_q <= free_q - size_q;
        if (rl_q == size_q) begin
          // remove entry idx: shift higher entries down
          sh_down_q     <= 1'b1;
          rd_is_shift_q <= 1'b1;
          sh_end_q      <= cnt_q - 1'b1;
          cnt_q         <= cnt_q - 1'b1;
        end
      end
      if (cmd_i.f_decide) begin
        if (m_prev) begin
          free_q <= free_q + size_q;
          if (m_next) begin
            sh_down_q     <= 1'b1;
            rd_is_shift_q <= 1'b1;
            sh_end_q      <= cnt_q - 1'b1;
            cnt_q         <= cnt_q - 1'b1;
          end
        end else if (m_next) begin
          free_q <= free_q + size_q;
        end else if (cnt_q < CntW'(TableEntries)) begin
          // insert at idx: shift entries up from the top
          free_q        <= free_q + size_q;
          sh_down_q     <= 1'b0;
          rd_is_shift_q <= 1'b1;
          sh_end_q      <= idx_q;
          idx_q         <= cnt_q;
          cnt_q         <= cnt_q + 1'b1;
          if (peak_q < cnt_q + 1'b1) peak_q <= cnt_q + 1'b1;
        end else begin
          st_q <= ffa_pkg::ST_LOST;
          if (lost_n_q != 32'hffff_ffff) lost_n_q <= lost_n_q + 1'b1;
          lost_b_q <= (lost_b_q > ~size_q) ? 32'hffff_ffff : lost_b_q + size_q;
        end
      end
    end
  end

  assign sts_o.is_free    = mode_q;
  assign sts_o.at_end     = idx_q == cnt_q;
  assign sts_o.fit        = rl_q >= size_q;
  assign sts_o.gt         = rs_q > addr_q;
  assign sts_o.zero_after = rl_q == size_q;
  assign sts_o.need_shift = !m_next && ((m_prev && 1'b0) || !m_prev) ?
                            (!m_prev && cnt_q < CntW'(TableEntries)) : (m_prev && m_next);
  assign sts_o.shift_down = sh_down_q;
  assign sts_o.shift_last = idx_q == sh_end_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o  <= st_q;
      granted_o <= gr_q;
      free_o    <= free_q;
      count_o   <= 9'(cnt_q);
      peak_o    <= 9'(peak_q);
      lost_n_o  <= lost_n_q;
      lost_b_o  <= lost_b_q;
    end
  end

endmodule

@@ hdl/first_fit_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top: first-fit free-region allocator
// Address-sorted free table with carving, coalescing and loss counters.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request word: mode (0 allocate, 1 free), round_to_page,
//   region_addr and region_size. rsp_o returns one result word per request:
//   status, granted_addr, free_bytes, region_count, peak_regions and the
//   saturating lost counters.
//   One request is in flight at a time. An allocate scans entries from the
//   bottom until the first fitting region; a free scans to its insert point
//   the same way. Removing or inserting an entry shifts the rest of the
//   table, again one entry at a time. The result word goes valid in the
//   same cycle as the block can take the next request.
//   The result sits in an output register. The next request is taken as soon
//   as that register is loaded; a finished request waits until the register
//   is free, so a stalled sink holds the block with one word in the register
//   and at most one more finished request.
//   Reset empties the table at once by clearing the region count; entries
//   above the count are never read, so no clearing pass is run.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_top #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;
  logic out_free;
  logic rsp_valid_q;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !rsp_valid_q || rsp_o.ready;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffa_dp #(.TableEntries(TABLE_ENTRIES)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .mode_i    (req_i.mode),
    .round_i   (req_i.round_to_page),
    .addr_i    (req_i.region_addr),
    .size_i    (req_i.region_size),
    .status_o  (rsp_o.status),
    .granted_o (rsp_o.granted_addr),
    .free_o    (rsp_o.free_bytes),
    .count_o   (rsp_o.region_count),
    .peak_o    (rsp_o.peak_regions),
    .lost_n_o  (rsp_o.lost_regions),
    .lost_b_o  (rsp_o.lost_bytes)
  );

  // Hold valid until the sink takes the word; load on emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end
  assign rsp_o.valid = rsp_valid_q;

  // A request is taken only while no result is being built.
  a_take_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.take && cmd.emit)) else $error("take and emit together");

  // A new result never overwrites one the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!rsp_valid_q || rsp_o.ready)) else $error("result overwritten");

  // An accepted request produces no result in the very next cycle.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !cmd.emit) else $error("result too early");

endmodule
